FILE: sv/battery_gauge_sampler_assert.svh
// Assertion macros shared by the battery gauge sampler checkers.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef BATTERY_GAUGE_SAMPLER_ASSERT_SVH
`define BATTERY_GAUGE_SAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bgs_pkg.sv
// Shared types, constants, band tables and threshold helper for the battery gauge sampler.
// No dependencies; used by bgs_band_map, bgs_core and battery_gauge_sampler.
package bgs_pkg;

  localparam int unsigned AdcW      = 12;
  localparam int unsigned PctW      = 7;
  localparam int unsigned LvlW      = 3;
  localparam int unsigned TickW     = 16;
  localparam int unsigned SumW      = 16;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 16;
  localparam int unsigned ThrW      = 17;  // holds AvgCount * code of the top voltage
  localparam int unsigned NumBands  = 9;

  localparam int unsigned AvgCountDefault = 10;

  // Millivolt conversion: mv = (MvScale * s) / AdcSpan
  localparam int unsigned MvScale = 3600;
  localparam int unsigned AdcSpan = 4096;

  localparam logic [TickW-1:0] ChgPause = TickW'(500);
  localparam logic [TickW-1:0] ChgRead  = TickW'(1000);
  localparam logic [TickW-1:0] ChgWrap  = TickW'(12000);

  localparam int unsigned TopMv   = 2050;
  localparam int unsigned EmptyMv = 1700;

  localparam logic [PctW-1:0] FullPct = PctW'(100);
  localparam logic [LvlW-1:0] FullLvl = LvlW'(4);

  localparam logic [PeriodW-1:0] SamplePeriodReset = PeriodW'(500);

  // Configuration register indexes
  typedef enum logic [0:0] {
    RegSamplePeriod = 1'b0,
    RegUnused       = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    CmdTick    = 1'b0,
    CmdInitial = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [AdcW-1:0] lo_mv;
    logic [AdcW-1:0] hi_mv;
    logic [PctW-1:0] pct;
    logic [LvlW-1:0] lvl;
  } band_t;

  localparam band_t ContigBands [NumBands] = '{
    '{lo_mv: 12'd2015, hi_mv: 12'd2049, pct: 7'd90, lvl: 3'd4},
    '{lo_mv: 12'd1980, hi_mv: 12'd2014, pct: 7'd80, lvl: 3'd3},
    '{lo_mv: 12'd1945, hi_mv: 12'd1979, pct: 7'd70, lvl: 3'd3},
    '{lo_mv: 12'd1910, hi_mv: 12'd1944, pct: 7'd60, lvl: 3'd3},
    '{lo_mv: 12'd1875, hi_mv: 12'd1909, pct: 7'd50, lvl: 3'd2},
    '{lo_mv: 12'd1840, hi_mv: 12'd1874, pct: 7'd40, lvl: 3'd2},
    '{lo_mv: 12'd1805, hi_mv: 12'd1839, pct: 7'd30, lvl: 3'd1},
    '{lo_mv: 12'd1770, hi_mv: 12'd1804, pct: 7'd20, lvl: 3'd1},
    '{lo_mv: 12'd1735, hi_mv: 12'd1769, pct: 7'd10, lvl: 3'd0}
  };

  localparam band_t GapBands [NumBands] = '{
    '{lo_mv: 12'd2008, hi_mv: 12'd2022, pct: 7'd90, lvl: 3'd4},
    '{lo_mv: 12'd1973, hi_mv: 12'd1987, pct: 7'd80, lvl: 3'd4},
    '{lo_mv: 12'd1938, hi_mv: 12'd1952, pct: 7'd70, lvl: 3'd3},
    '{lo_mv: 12'd1903, hi_mv: 12'd1917, pct: 7'd60, lvl: 3'd3},
    '{lo_mv: 12'd1868, hi_mv: 12'd1882, pct: 7'd50, lvl: 3'd2},
    '{lo_mv: 12'd1833, hi_mv: 12'd1847, pct: 7'd40, lvl: 3'd2},
    '{lo_mv: 12'd1798, hi_mv: 12'd1812, pct: 7'd30, lvl: 3'd1},
    '{lo_mv: 12'd1763, hi_mv: 12'd1777, pct: 7'd20, lvl: 3'd1},
    '{lo_mv: 12'd1728, hi_mv: 12'd1742, pct: 7'd10, lvl: 3'd0}
  };

  // Smallest converter code whose truncated millivolt value reaches mv.
  function automatic int unsigned mv_code(input int unsigned mv);
    return (mv * AdcSpan + MvScale - 1) / MvScale;
  endfunction

  typedef struct packed {
    logic [AdcW-1:0] adc_sample;
    logic            charging;
    cmd_e            command;
  } in_item_t;

  typedef struct packed {
    logic            updated;
    logic            charge_inhibit;
    logic [LvlW-1:0] bar_level;
    logic [PctW-1:0] percent;
  } out_item_t;

  typedef struct packed {
    logic            hit;
    logic [PctW-1:0] percent;
    logic [LvlW-1:0] level;
  } map_res_t;

endpackage

FILE: sv/bgs_band_map.sv
// Band lookup: compares a scaled converter value against constant code thresholds.
// Depends on bgs_pkg (band tables, mv_code, map_res_t).
module bgs_band_map #(
  parameter int unsigned Scale = 1,
  parameter bit          Gaps  = 1'b0
) (
  input  logic [bgs_pkg::SumW-1:0] value_i,
  output bgs_pkg::map_res_t        res_o
);

  localparam int unsigned ThrW = bgs_pkg::ThrW;
  localparam int unsigned NB   = bgs_pkg::NumBands;

  // Full and empty limits in code domain, times Scale for a summed value
  localparam logic [ThrW-1:0] TopThr   = ThrW'(Scale * bgs_pkg::mv_code(bgs_pkg::TopMv));
  localparam logic [ThrW-1:0] EmptyThr =
    ThrW'(Scale * bgs_pkg::mv_code(Gaps ? bgs_pkg::EmptyMv + 1 : bgs_pkg::EmptyMv));

  logic [ThrW-1:0] value_ext;
  logic [NB-1:0]   hit;
  logic [bgs_pkg::PctW-1:0] pct_m [NB];
  logic [bgs_pkg::LvlW-1:0] lvl_m [NB];

  assign value_ext = ThrW'(value_i);

  for (genvar i = 0; i < NB; i++) begin : g_band
    localparam bgs_pkg::band_t Band = Gaps ? bgs_pkg::GapBands[i] : bgs_pkg::ContigBands[i];
    localparam logic [ThrW-1:0] LoThr =
      ThrW'(Scale * bgs_pkg::mv_code(int'(unsigned'(Band.lo_mv))));
    localparam logic [ThrW-1:0] HiThr =
      ThrW'(Scale * bgs_pkg::mv_code(int'(unsigned'(Band.hi_mv)) + 1));
    assign hit[i]   = (value_ext >= LoThr) && (value_ext < HiThr);
    assign pct_m[i] = hit[i] ? Band.pct : '0;
    assign lvl_m[i] = hit[i] ? Band.lvl : '0;
  end

  always_comb begin
    logic [bgs_pkg::PctW-1:0] pct_or;
    logic [bgs_pkg::LvlW-1:0] lvl_or;
    pct_or = '0;
    lvl_or = '0;
    // bands are disjoint, so at most one term is non-zero
    for (int i = 0; i < NB; i++) begin
      pct_or = pct_or | pct_m[i];
      lvl_or = lvl_or | lvl_m[i];
    end
    priority if (value_ext >= TopThr) begin
      res_o = '{hit: 1'b1, percent: bgs_pkg::FullPct, level: bgs_pkg::FullLvl};
    end else if (value_ext < EmptyThr) begin
      res_o = '{hit: 1'b1, percent: '0, level: '0};
    end else begin
      res_o = '{hit: |hit, percent: pct_or, level: lvl_or};
    end
  end

endmodule

FILE: sv/bgs_core.sv
// Tick scheduler and held gauge state; produces one result per item it is handed.
// Depends on bgs_pkg and bgs_band_map.
module bgs_core #(
  parameter int unsigned AvgCount = bgs_pkg::AvgCountDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  bgs_pkg::in_item_t           item_i,
  input  logic [bgs_pkg::PeriodW-1:0] period_i,
  output bgs_pkg::out_item_t          result_o
);

  localparam int unsigned IdxW = (AvgCount > 1) ? $clog2(AvgCount) : 1;
  localparam int unsigned TickW = bgs_pkg::TickW;
  localparam int unsigned SumW  = bgs_pkg::SumW;

  logic [TickW-1:0]         tick_q, tick_d, tick_inc;
  logic                     inhibit_q, inhibit_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [IdxW:0]            idx_next;
  logic [SumW-1:0]          sum_q, sum_d, sum_add;
  logic [bgs_pkg::PctW-1:0] pct_q, pct_d;
  logic [bgs_pkg::LvlW-1:0] lvl_q, lvl_d;
  logic [SumW-1:0]          sample_ext;

  bgs_pkg::map_res_t contig_res, tick_res, avg_res;

  assign sample_ext = SumW'(item_i.adc_sample);
  assign tick_inc   = tick_q + TickW'(1);
  assign sum_add    = sum_q + sample_ext;
  assign idx_next   = (IdxW + 1)'(idx_q) + (IdxW + 1)'(1);

  bgs_band_map #(.Scale(1), .Gaps(1'b0)) u_map_contig (
    .value_i(sample_ext),
    .res_o  (contig_res)
  );

  bgs_band_map #(.Scale(1), .Gaps(1'b1)) u_map_tick (
    .value_i(sample_ext),
    .res_o  (tick_res)
  );

  // Average compared in the sum domain: thresholds carry the AvgCount factor
  bgs_band_map #(.Scale(AvgCount), .Gaps(1'b1)) u_map_avg (
    .value_i(sum_add),
    .res_o  (avg_res)
  );

  always_comb begin
    bgs_pkg::map_res_t sel;
    logic              upd;
    tick_d    = tick_q;
    inhibit_d = inhibit_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    sel       = '0;
    upd       = 1'b0;
    unique case (item_i.command)
      bgs_pkg::CmdInitial: begin
        sel = contig_res;
        upd = 1'b1;
      end
      bgs_pkg::CmdTick: begin
        tick_d = tick_inc;
        if (item_i.charging) begin
          if (tick_inc == bgs_pkg::ChgPause) inhibit_d = 1'b1;
          if (tick_inc == bgs_pkg::ChgRead) begin
            sel       = tick_res;
            upd       = 1'b1;
            inhibit_d = 1'b0;
          end
          if (tick_inc >= bgs_pkg::ChgWrap) begin
            tick_d    = '0;
            inhibit_d = 1'b0;
          end
        end else if (tick_inc >= period_i) begin
          tick_d = '0;
          if (idx_next >= (IdxW + 1)'(AvgCount)) begin
            sel   = avg_res;
            upd   = 1'b1;
            idx_d = '0;
            sum_d = '0;
          end else begin
            idx_d = idx_next[IdxW-1:0];
            sum_d = sum_add;
          end
        end
      end
      default: ;
    endcase
    pct_d = sel.hit ? sel.percent : pct_q;
    lvl_d = sel.hit ? sel.level   : lvl_q;
    result_o = '{updated: upd, charge_inhibit: inhibit_d, bar_level: lvl_d, percent: pct_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      inhibit_q <= 1'b0;
      idx_q     <= '0;
      sum_q     <= '0;
      pct_q     <= '0;
      lvl_q     <= '0;
    end else if (fire_i) begin
      tick_q    <= tick_d;
      inhibit_q <= inhibit_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      pct_q     <= pct_d;
      lvl_q     <= lvl_d;
    end
  end

endmodule

FILE: sv/battery_gauge_sampler.sv
// Battery gauge sampler top level: stream ports, input and result registers, APB register.
// Depends on bgs_pkg and bgs_core (which uses bgs_band_map).
// An accepted item waits in the input register and its result in the result register.
// Throughput: one item per cycle; the input side stalls only while a result waits downstream.
// Reset: asynchronous, active low; clears the tick, sample and held gauge state and
//   sets sample_period to 500.
module battery_gauge_sampler #(
  parameter int unsigned AvgCount = bgs_pkg::AvgCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [0] charging, [12:1] adc_sample, [15:13] zero
  input  logic [bgs_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [0] command
  input  logic                          s_axis_tuser_i,
  // result items
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [6:0] percent, [9:7] bar_level, [10] charge_inhibit, [15:11] zero
  output logic [bgs_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // [0] updated
  output logic                          m_axis_tuser_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned PeriodW = bgs_pkg::PeriodW;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [PeriodW-1:0]  period_q;
  bgs_pkg::reg_idx_e   reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = bgs_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= bgs_pkg::SamplePeriodReset;
    end else if (cfg_wr && (reg_idx == bgs_pkg::RegSamplePeriod)) begin
      period_q <= pwdata[PeriodW-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      bgs_pkg::RegSamplePeriod: prdata = 32'(period_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register: take a new item when empty or whenever the held one moves on
  // ---------------------------------------------------------------------------
  bgs_pkg::in_item_t  in_q;
  logic               in_valid_q, in_valid_d;
  logic               s_fire, advance, m_fire;

  bgs_pkg::out_item_t out_q, result;
  logic               out_valid_q, out_valid_d;

  // advance: the held item is worked and its result lands in the result register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = out_valid_q && m_axis_tready_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.command    <= bgs_pkg::cmd_e'(s_axis_tuser_i);
      in_q.charging   <= s_axis_tdata_i[0];
      in_q.adc_sample <= s_axis_tdata_i[bgs_pkg::AdcW:1];
    end
  end

  // ---------------------------------------------------------------------------
  // Scheduler and band mapping; state advances with the held item
  // ---------------------------------------------------------------------------
  bgs_core #(.AvgCount(AvgCount)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (in_q),
    .period_i(period_q),
    .result_o(result)
  );

  // ---------------------------------------------------------------------------
  // Result register: hold the result until the sink takes it
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = bgs_pkg::OutTdataW'({out_q.charge_inhibit, out_q.bar_level,
                                                out_q.percent});
  assign m_axis_tuser_o  = out_q.updated;

endmodule

FILE: sv/battery_gauge_sampler_checker.sv
// Port-level checker for the battery gauge sampler, bound to the top level.
// Depends on battery_gauge_sampler_assert.svh and bgs_pkg.
`include "battery_gauge_sampler_assert.svh"

module battery_gauge_sampler_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [bgs_pkg::OutTdataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o
);

  logic [6:0] pct;
  logic [2:0] lvl;

  assign pct = m_axis_tdata_o[6:0];
  assign lvl = m_axis_tdata_o[9:7];

  // stalled result keeps its payload
  `BGS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // percent and bars stay in range and agree at the full and empty ends
  `BGS_ASSERT_NOW(a_gauge_range, clk_i, rst_ni, m_axis_tvalid_o, (pct <= 7'd100) && (lvl <= 3'd4) && (pct != 7'd100 || lvl == 3'd4) && (pct != 7'd0 || lvl == 3'd0), "percent and bar level disagree")

  // padding above the result fields stays clear
  `BGS_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[15:11] == 5'd0, "tdata padding not zero")

endmodule

bind battery_gauge_sampler battery_gauge_sampler_checker u_checker (.*);
